// ===== hw/rtl/sti_pkg.sv =====
// shared widths and types for the segment/triangle intersection pipeline
// no dependencies
`timescale 1ns / 1ps
package sti_pkg;
	localparam int CoordBits = 16;
	localparam int FracBits  = 16;
	localparam int PointBits = 48;
	localparam int DiffBits  = CoordBits + 1;
	localparam int CrossBits = 2 * DiffBits + 1;
	localparam int DotBits   = CrossBits + DiffBits + 2;
	localparam int QBits     = FracBits + 1;

	typedef logic signed [DiffBits-1:0]  diff_t;
	typedef logic signed [CrossBits-1:0] cross_t;
	typedef logic signed [DotBits-1:0]   dot_t;
	typedef diff_t  dvec_t  [3];
	typedef cross_t cvec_t  [3];

	typedef struct packed {
		logic             ok;
		logic [QBits-1:0] q;
	} div_res_t;

	function automatic diff_t coord(input logic [PointBits-1:0] p, input int k);
		logic signed [CoordBits-1:0] v;
		begin
			v = p[k*CoordBits +: CoordBits];
			return diff_t'(v);
		end
	endfunction
endpackage

// ===== hw/rtl/sti_geom.sv =====
// geometry stages: edges, normal, edge-cross, dot products and bound checks
// depends on sti_pkg
`timescale 1ns / 1ps
module sti_geom import sti_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [PointBits-1:0] seg_start,
	input  logic [PointBits-1:0] seg_end,
	input  logic [PointBits-1:0] vertex_a,
	input  logic [PointBits-1:0] vertex_b,
	input  logic [PointBits-1:0] vertex_c,
	output logic                 out_valid,
	output logic                 out_ok,
	output dot_t                 out_tn,
	output dot_t                 out_den
);
	dvec_t ab_s1, ac_s1, qp_s1, ap_s1;
	logic  v_s1, v_s2, v_s3;
	cvec_t n_s2, e_s2;
	dvec_t ab_s2, ac_s2, qp_s2, ap_s2;
	dot_t  den_s3, tn_s3, v3_s3, w_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ab_s1[k] <= coord(vertex_b, k) - coord(vertex_a, k);
				ac_s1[k] <= coord(vertex_c, k) - coord(vertex_a, k);
				qp_s1[k] <= coord(seg_start, k) - coord(seg_end, k);
				ap_s1[k] <= coord(seg_start, k) - coord(vertex_a, k);
			end
			for (int k = 0; k < 3; k++) begin
				n_s2[k] <= cross_t'(ab_s1[(k+1)%3] * ac_s1[(k+2)%3])
					- cross_t'(ab_s1[(k+2)%3] * ac_s1[(k+1)%3]);
				e_s2[k] <= cross_t'(qp_s1[(k+1)%3] * ap_s1[(k+2)%3])
					- cross_t'(qp_s1[(k+2)%3] * ap_s1[(k+1)%3]);
			end
			ab_s2 <= ab_s1; ac_s2 <= ac_s1; qp_s2 <= qp_s1; ap_s2 <= ap_s1;
			den_s3 <= dot_t'(qp_s2[0] * n_s2[0]) + dot_t'(qp_s2[1] * n_s2[1])
				+ dot_t'(qp_s2[2] * n_s2[2]);
			tn_s3 <= dot_t'(ap_s2[0] * n_s2[0]) + dot_t'(ap_s2[1] * n_s2[1])
				+ dot_t'(ap_s2[2] * n_s2[2]);
			v3_s3 <= dot_t'(ac_s2[0] * e_s2[0]) + dot_t'(ac_s2[1] * e_s2[1])
				+ dot_t'(ac_s2[2] * e_s2[2]);
			w_s3 <= -(dot_t'(ab_s2[0] * e_s2[0]) + dot_t'(ab_s2[1] * e_s2[1])
				+ dot_t'(ab_s2[2] * e_s2[2]));
		end
	end

	always_comb begin
		out_valid = v_s3;
		out_tn    = tn_s3;
		out_den   = den_s3;
		out_ok    = (den_s3 > 0) && (tn_s3 >= 0) && (tn_s3 <= den_s3)
			&& (v3_s3 >= 0) && (v3_s3 <= den_s3) && (w_s3 >= 0)
			&& ((v3_s3 + w_s3) <= den_s3);
	end
endmodule

// ===== hw/rtl/sti_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on sti_pkg
`timescale 1ns / 1ps
module sti_div import sti_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  logic     in_ok,
	input  dot_t     in_tn,
	input  dot_t     in_den,
	output logic     out_valid,
	output div_res_t out_res
);
	localparam int N = QBits;
	logic [N-1:0]          vld_q;
	logic                  ok_q  [N];
	logic [DotBits:0]      rem_q [N];
	logic [DotBits-1:0]    den_q [N];
	logic [QBits-1:0]      quo_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[N-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				logic [DotBits:0]   r;
				logic [DotBits-1:0] d;
				logic [QBits-1:0]   qq;
				if (i == 0) begin
					r  = {1'b0, in_tn};
					d  = in_den;
					qq = '0;
					ok_q[i] <= in_ok;
				end else begin
					r  = {rem_q[i-1][DotBits-1:0], 1'b0};
					d  = den_q[i-1];
					qq = {quo_q[i-1][QBits-2:0], 1'b0};
					ok_q[i] <= ok_q[i-1];
				end
				if (r >= {1'b0, d}) begin
					r     = r - {1'b0, d};
					qq[0] = 1'b1;
				end
				rem_q[i] <= r;
				den_q[i] <= d;
				quo_q[i] <= qq;
			end
		end
	end

	assign out_valid  = vld_q[N-1];
	assign out_res.ok = ok_q[N-1];
	assign out_res.q  = ok_q[N-1] ? quo_q[N-1] : '0;
endmodule

// ===== hw/rtl/segment_triangle_intersect.sv =====
// segment/triangle one-sided hit test: geometry pipe, then divider pipe, then output register
// throughput one request per cycle; the whole pipe advances unless the output is stalled
// arst_n clears all valid bits; payload registers are not reset
// depends on sti_pkg, sti_geom, sti_div
`timescale 1ns / 1ps
module segment_triangle_intersect import sti_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [239:0] s_axis_tdata,  // seg_start, seg_end, vertex_a, vertex_b, vertex_c
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [23:0]  m_axis_tdata   // hit, hit_fraction, zero pad
);
	logic     en, g_valid, g_ok, d_valid;
	dot_t     g_tn, g_den;
	div_res_t d_res;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	sti_geom u_geom (
		.clk, .arst_n, .en,
		.in_valid (s_axis_tvalid),
		.seg_start(s_axis_tdata[47:0]),
		.seg_end  (s_axis_tdata[95:48]),
		.vertex_a (s_axis_tdata[143:96]),
		.vertex_b (s_axis_tdata[191:144]),
		.vertex_c (s_axis_tdata[239:192]),
		.out_valid(g_valid), .out_ok(g_ok), .out_tn(g_tn), .out_den(g_den)
	);

	sti_div u_div (
		.clk, .arst_n, .en,
		.in_valid(g_valid), .in_ok(g_ok), .in_tn(g_tn), .in_den(g_den),
		.out_valid(d_valid), .out_res(d_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (en) m_axis_tdata <= {6'd0, d_res.q, d_res.ok};
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[17:1] == '0)
		else $error("fraction nonzero without hit");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("not ready with empty output");
endmodule
